// File: hw/rtl/lmpc_pkg.sv
// types, codes and constants shared by the lift motor controller files
package lmpc_pkg;

    localparam int TRAVEL_TICKS = 1024;
    localparam int FULL_HEIGHT  = 100;

    localparam int TRAVEL_W = $clog2(TRAVEL_TICKS + 1);
    localparam int PROD_W   = TRAVEL_W + 8;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [TRAVEL_W-1:0] TRAVEL_END  = TRAVEL_W'(TRAVEL_TICKS);
    localparam logic [TRAVEL_W-1:0] TRAVEL_MID  = TRAVEL_W'(TRAVEL_TICKS / 2);
    localparam logic [7:0]          HEIGHT_FULL = 8'(FULL_HEIGHT);
    localparam logic [7:0]          HEIGHT_MID  = 8'(FULL_HEIGHT / 2);

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_SET  = 2'd1;
    localparam logic [1:0] FUNC_STOP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_TRIP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_TRIP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UP_TICKS      = 3'd6;

    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PAUSE = 2'd1,
        PH_UP    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [11:0] current_limit;
        logic [7:0]  up_trip_count;
        logic [7:0]  down_trip_count;
        logic [7:0]  upper_limit_height;
        logic [7:0]  lower_limit_height;
        logic [7:0]  backoff_pause_ticks;
        logic [7:0]  backoff_up_ticks;
    } cfg_t;

    typedef struct packed {
        logic [TRAVEL_W-1:0] travel_count;
        logic [7:0]          height_estimate;
        cmd_t                motion_command;
        logic [7:0]          goal_height;
        logic                goal_valid;
        logic                arrived_flag;
        logic [7:0]          overcurrent_run;
        logic [1:0]          fault_bits;
        logic                homed_flag;
        phase_t              backoff_phase;
        logic [7:0]          backoff_timer;
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  target_height;
        logic        upper_switch_n;
        logic        lower_switch_n;
        logic [11:0] motor_current;
    } item_t;

    typedef struct packed {
        logic       motor_enable;
        logic       direction_up;
        logic [7:0] height;
        logic       arrived;
        logic [1:0] limit_flags;
        logic [1:0] overcurrent_flags;
        logic       homed;
    } result_t;

endpackage

// File: hw/rtl/lmpc_step.sv
// next-state and result logic for one transaction of the lift motor controller
module lmpc_step
    import lmpc_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  st,
    input  item_t   item,
    output state_t  st_next,
    output result_t res
);

    logic [1:0]        limit;
    logic              enable;
    logic              dir_up;
    logic [7:0]        run_inc;
    logic [7:0]        trip;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [7:0]        up_timer;

    always_comb
    begin
        st_next  = st;
        enable   = 1'b0;
        dir_up   = 1'b0;
        limit    = 2'b00;
        run_inc  = st.overcurrent_run + 8'd1;
        trip     = (st.motion_command == CMD_UP) ? cfg.up_trip_count : cfg.down_trip_count;
        prod     = PROD_W'(st.travel_count) * PROD_W'(FULL_HEIGHT);
        quot     = prod / PROD_W'(TRAVEL_TICKS);
        up_timer = (st.backoff_phase == PH_PAUSE) ? cfg.backoff_up_ticks : st.backoff_timer;

        if (!item.upper_switch_n && st.height_estimate > cfg.upper_limit_height)
        begin
            limit[0] = 1'b1;
        end
        if (!item.lower_switch_n && st.height_estimate < cfg.lower_limit_height)
        begin
            limit[1] = 1'b1;
        end

        case (item.func)
            FUNC_SET:
            begin
                st_next.goal_height = item.target_height;
                st_next.goal_valid  = 1'b1;
            end
            FUNC_STOP:
            begin
                st_next.motion_command = CMD_STOP;
                st_next.goal_valid     = 1'b0;
            end
            FUNC_TICK:
            begin
                if (st.backoff_phase != PH_IDLE)
                begin
                    // back-off sequence: pause, then timed upward pulse
                    if (st.backoff_phase == PH_PAUSE && st.backoff_timer != 8'd0)
                    begin
                        st_next.backoff_timer = st.backoff_timer - 8'd1;
                    end
                    else if (up_timer != 8'd0)
                    begin
                        st_next.backoff_phase = PH_UP;
                        st_next.backoff_timer = up_timer - 8'd1;
                        enable = 1'b1;
                        dir_up = 1'b1;
                    end
                    else
                    begin
                        st_next.backoff_phase = PH_IDLE;
                        st_next.backoff_timer = up_timer;
                        st_next.homed_flag    = 1'b1;
                    end
                end
                else
                begin
                    // overcurrent run counting in the direction of motion
                    if (st.motion_command == CMD_UP || st.motion_command == CMD_DOWN)
                    begin
                        st_next.fault_bits = (st.motion_command == CMD_UP) ?
                                             (st.fault_bits & 2'b01) : (st.fault_bits & 2'b10);
                        if (item.motor_current > cfg.current_limit)
                        begin
                            if (run_inc >= trip)
                            begin
                                st_next.overcurrent_run = 8'd0;
                                if (st.motion_command == CMD_UP)
                                begin
                                    st_next.fault_bits[0] = 1'b1;
                                end
                                else
                                begin
                                    st_next.fault_bits[1] = 1'b1;
                                end
                            end
                            else
                            begin
                                st_next.overcurrent_run = run_inc;
                            end
                        end
                        else
                        begin
                            st_next.overcurrent_run = 8'd0;
                        end
                    end

                    st_next.height_estimate = (quot > PROD_W'(255)) ? 8'hFF : quot[7:0];

                    // steering toward the goal
                    if (st.goal_valid)
                    begin
                        if (st.goal_height == HEIGHT_FULL)
                        begin
                            if (limit == 2'b01)
                            begin
                                st_next.arrived_flag = 1'b1;
                            end
                            else
                            begin
                                st_next.motion_command = CMD_UP;
                            end
                        end
                        else if (st.goal_height == 8'd0)
                        begin
                            if (limit == 2'b10)
                            begin
                                st_next.arrived_flag = 1'b1;
                            end
                            else
                            begin
                                st_next.motion_command = CMD_DOWN;
                            end
                        end
                        else if (st_next.height_estimate < st.goal_height)
                        begin
                            st_next.motion_command = CMD_UP;
                            st_next.arrived_flag   = 1'b0;
                        end
                        else if (st_next.height_estimate == st.goal_height)
                        begin
                            st_next.motion_command = CMD_STOP;
                            st_next.arrived_flag   = 1'b1;
                        end
                        else
                        begin
                            st_next.motion_command = CMD_DOWN;
                            st_next.arrived_flag   = 1'b0;
                        end
                    end
                    else
                    begin
                        st_next.arrived_flag = 1'b0;
                    end

                    // motor drive and travel counter
                    case (st_next.motion_command)
                        CMD_UP:
                        begin
                            st_next.homed_flag = 1'b0;
                            if (limit[0] || st_next.fault_bits[0])
                            begin
                                st_next.travel_count = TRAVEL_END;
                            end
                            else if (st.travel_count < TRAVEL_END)
                            begin
                                enable = 1'b1;
                                dir_up = 1'b1;
                                st_next.travel_count = st.travel_count + TRAVEL_W'(1);
                            end
                        end
                        CMD_DOWN:
                        begin
                            if (limit[1] || st_next.fault_bits[1])
                            begin
                                st_next.travel_count = '0;
                                if (!st.homed_flag)
                                begin
                                    st_next.backoff_phase = PH_PAUSE;
                                    st_next.backoff_timer = cfg.backoff_pause_ticks;
                                end
                            end
                            else
                            begin
                                enable = !st.homed_flag;
                                if (st.travel_count != '0)
                                begin
                                    st_next.travel_count = st.travel_count - TRAVEL_W'(1);
                                end
                            end
                        end
                        CMD_STOP:
                        begin
                            st_next.goal_valid = 1'b0;
                            if (limit[0])
                            begin
                                st_next.travel_count = TRAVEL_END;
                            end
                            else if (limit[1])
                            begin
                                st_next.travel_count = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        res.motor_enable      = enable;
        res.direction_up      = dir_up;
        res.height            = st_next.height_estimate;
        res.arrived           = st_next.arrived_flag;
        res.limit_flags       = limit;
        res.overcurrent_flags = st_next.fault_bits;
        res.homed             = st_next.homed_flag;
    end

endmodule

// File: hw/rtl/lift_motor_position_controller_core.sv
// top level of the lift motor position controller: registers, config port and handshake
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    func, target_height, switches, motor_current
//  out       output     out_valid / out_stall  motor_enable .. homed
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low; the result passes through the
// input register, then next-state logic into the result register
// reset loads the default config values and the mid-travel position
// out_stall holds the result register; in_stall rises with it while the input register
// is full, and an empty input register takes one more transaction first
module lift_motor_position_controller_core
    import lmpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [7:0]           target_height,
    input  logic                 upper_switch_n,
    input  logic                 lower_switch_n,
    input  logic [11:0]          motor_current,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 motor_enable,
    output logic                 direction_up,
    output logic [7:0]           height,
    output logic                 arrived,
    output logic [1:0]           limit_flags,
    output logic [1:0]           overcurrent_flags,
    output logic                 homed,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    state_t  st_reg;
    state_t  st_next;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    advance;
    logic    fire;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;

    lmpc_step u_step
    (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CURRENT_LIMIT: cfg_next.current_limit       = cfg_data;
                REG_UP_TRIP:       cfg_next.up_trip_count       = cfg_data[7:0];
                REG_DOWN_TRIP:     cfg_next.down_trip_count     = cfg_data[7:0];
                REG_UPPER_HEIGHT:  cfg_next.upper_limit_height  = cfg_data[7:0];
                REG_LOWER_HEIGHT:  cfg_next.lower_limit_height  = cfg_data[7:0];
                REG_PAUSE_TICKS:   cfg_next.backoff_pause_ticks = cfg_data[7:0];
                REG_UP_TICKS:      cfg_next.backoff_up_ticks    = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_limit       <= 12'd1000;
            cfg_reg.up_trip_count       <= 8'd20;
            cfg_reg.down_trip_count     <= 8'd10;
            cfg_reg.upper_limit_height  <= 8'd60;
            cfg_reg.lower_limit_height  <= 8'd30;
            cfg_reg.backoff_pause_ticks <= 8'd5;
            cfg_reg.backoff_up_ticks    <= 8'd30;
            st_reg.travel_count         <= TRAVEL_MID;
            st_reg.height_estimate      <= HEIGHT_MID;
            st_reg.motion_command       <= CMD_STOP;
            st_reg.goal_height          <= 8'd0;
            st_reg.goal_valid           <= 1'b0;
            st_reg.arrived_flag         <= 1'b0;
            st_reg.overcurrent_run      <= 8'd0;
            st_reg.fault_bits           <= 2'b00;
            st_reg.homed_flag           <= 1'b0;
            st_reg.backoff_phase        <= PH_IDLE;
            st_reg.backoff_timer        <= 8'd0;
            item_valid_reg              <= 1'b0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (fire)
            begin
                st_reg <= st_next;
            end
            if (advance)
            begin
                out_valid_reg <= item_valid_reg;
            end
            if (!in_stall)
            begin
                item_valid_reg <= in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.func           <= func;
            item_reg.target_height  <= target_height;
            item_reg.upper_switch_n <= upper_switch_n;
            item_reg.lower_switch_n <= lower_switch_n;
            item_reg.motor_current  <= motor_current;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign motor_enable      = res_reg.motor_enable;
    assign direction_up      = res_reg.direction_up;
    assign height            = res_reg.height;
    assign arrived           = res_reg.arrived;
    assign limit_flags       = res_reg.limit_flags;
    assign overcurrent_flags = res_reg.overcurrent_flags;
    assign homed             = res_reg.homed;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg)
        else $error("input stalled with empty input register");

    a_dir_only_when_driven: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && direction_up |-> motor_enable)
        else $error("direction up reported with motor off");

    a_no_down_when_homed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motor_enable && !direction_up |-> !homed)
        else $error("downward drive while homed");

    a_backoff_freezes_height: assert property (@(posedge clk) disable iff (!rst_n)
        fire && st_reg.backoff_phase != PH_IDLE |=>
        st_reg.height_estimate == $past(st_reg.height_estimate))
        else $error("height moved during back-off");

    a_travel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.travel_count <= TRAVEL_END)
        else $error("travel counter beyond full travel");
`endif

endmodule

// File: dv/lmpc_motion_check.sv
// checker for the lift controller: predicts each result from accepted transactions and compares
`timescale 1ns / 100ps
module lmpc_motion_check
    import lmpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [7:0]           target_height,
    input  logic                 upper_switch_n,
    input  logic                 lower_switch_n,
    input  logic [11:0]          motor_current,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 motor_enable,
    input  logic                 direction_up,
    input  logic [7:0]           height,
    input  logic                 arrived,
    input  logic [1:0]           limit_flags,
    input  logic [1:0]           overcurrent_flags,
    input  logic                 homed,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   waiting,
    output int                   fails
);

    cfg_t                regs;
    logic [TRAVEL_W-1:0] travel;
    logic [7:0]          est_height;
    logic [7:0]          goal;
    logic [7:0]          oc_run;
    logic [7:0]          bo_timer;
    cmd_t                motion;
    phase_t              phase;
    logic                goal_set;
    logic                arrived_q;
    logic                homed_q;
    logic [1:0]          faults;
    result_t             status_due [$];
    int                  bad;

    task automatic count_overcurrent(input logic [11:0] amps, input logic [7:0] trip,
                                     input int dir);
        begin
            faults[1 - dir] = 1'b0;
            if (amps > regs.current_limit)
            begin
                oc_run = oc_run + 8'd1;
                if (oc_run >= trip)
                begin
                    oc_run = '0;
                    faults[dir] = 1'b1;
                end
            end
            else
            begin
                oc_run = '0;
            end
        end
    endtask

    task automatic advance_lift(input item_t it, output result_t r);
        logic [1:0] lim;
        logic       en;
        logic       up;
        int         h;
        begin
            lim = 2'b00;
            en  = 1'b0;
            up  = 1'b0;
            if (!it.upper_switch_n && est_height > regs.upper_limit_height)
                lim[0] = 1'b1;
            if (!it.lower_switch_n && est_height < regs.lower_limit_height)
                lim[1] = 1'b1;
            case (it.func)
                FUNC_SET:
                begin
                    goal     = it.target_height;
                    goal_set = 1'b1;
                end
                FUNC_STOP:
                begin
                    motion   = CMD_STOP;
                    goal_set = 1'b0;
                end
                FUNC_TICK:
                begin
                    if (phase != PH_IDLE)
                    begin
                        if (phase == PH_PAUSE && bo_timer != 0)
                        begin
                            bo_timer = bo_timer - 8'd1;
                        end
                        else
                        begin
                            if (phase == PH_PAUSE)
                            begin
                                phase    = PH_UP;
                                bo_timer = regs.backoff_up_ticks;
                            end
                            if (bo_timer != 0)
                            begin
                                bo_timer = bo_timer - 8'd1;
                                en       = 1'b1;
                                up       = 1'b1;
                            end
                            else
                            begin
                                phase   = PH_IDLE;
                                homed_q = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (motion == CMD_UP)
                            count_overcurrent(it.motor_current, regs.up_trip_count, 0);
                        else if (motion == CMD_DOWN)
                            count_overcurrent(it.motor_current, regs.down_trip_count, 1);

                        h = (int'(travel) * FULL_HEIGHT) / TRAVEL_TICKS;
                        est_height = (h > 255) ? 8'hFF : 8'(h);

                        if (goal_set)
                        begin
                            if (goal == HEIGHT_FULL)
                            begin
                                if (lim == 2'b01)
                                    arrived_q = 1'b1;
                                else
                                    motion = CMD_UP;
                            end
                            else if (goal == 8'd0)
                            begin
                                if (lim == 2'b10)
                                    arrived_q = 1'b1;
                                else
                                    motion = CMD_DOWN;
                            end
                            else if (est_height < goal)
                            begin
                                motion    = CMD_UP;
                                arrived_q = 1'b0;
                            end
                            else if (est_height == goal)
                            begin
                                motion    = CMD_STOP;
                                arrived_q = 1'b1;
                            end
                            else
                            begin
                                motion    = CMD_DOWN;
                                arrived_q = 1'b0;
                            end
                        end
                        else
                        begin
                            arrived_q = 1'b0;
                        end

                        case (motion)
                            CMD_UP:
                            begin
                                homed_q = 1'b0;
                                if (!lim[0] && !faults[0] && travel < TRAVEL_END)
                                begin
                                    en = 1'b1;
                                    up = 1'b1;
                                end
                                if (lim[0] || faults[0])
                                    travel = TRAVEL_END;
                                else if (travel < TRAVEL_END)
                                    travel = travel + 1'b1;
                            end
                            CMD_DOWN:
                            begin
                                if (homed_q)
                                begin
                                    en = 1'b0;
                                end
                                else if (lim[1] || faults[1])
                                begin
                                    phase    = PH_PAUSE;
                                    bo_timer = regs.backoff_pause_ticks;
                                end
                                else
                                begin
                                    en = 1'b1;
                                end
                                if (lim[1] || faults[1])
                                    travel = '0;
                                else if (travel != 0)
                                    travel = travel - 1'b1;
                            end
                            CMD_STOP:
                            begin
                                goal_set = 1'b0;
                                if (lim[0])
                                    travel = TRAVEL_END;
                                else if (lim[1])
                                    travel = '0;
                            end
                            default:
                            begin
                                en = 1'b0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    en = 1'b0;
                end
            endcase
            r.motor_enable      = en;
            r.direction_up      = up;
            r.height            = est_height;
            r.arrived           = arrived_q;
            r.limit_flags       = lim;
            r.overcurrent_flags = faults;
            r.homed             = homed_q;
        end
    endtask

    task automatic compare_field(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
        begin
            if (want !== got)
            begin
                $display("%0t lmpc: %s expected %0d got %0d", $time, what, want, got);
                bad++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   it;
        result_t seen;
        result_t due;
        if (!rst_n)
        begin
            regs       = '{12'd1000, 8'd20, 8'd10, 8'd60, 8'd30, 8'd5, 8'd30};
            travel     = TRAVEL_MID;
            est_height = HEIGHT_MID;
            motion     = CMD_STOP;
            goal       = '0;
            goal_set   = 1'b0;
            arrived_q  = 1'b0;
            oc_run     = '0;
            faults     = '0;
            homed_q    = 1'b0;
            phase      = PH_IDLE;
            bo_timer   = '0;
            status_due.delete();
            bad = 0;
            waiting <= 0;
            fails   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CURRENT_LIMIT: regs.current_limit       = cfg_data;
                    REG_UP_TRIP:       regs.up_trip_count       = cfg_data[7:0];
                    REG_DOWN_TRIP:     regs.down_trip_count     = cfg_data[7:0];
                    REG_UPPER_HEIGHT:  regs.upper_limit_height  = cfg_data[7:0];
                    REG_LOWER_HEIGHT:  regs.lower_limit_height  = cfg_data[7:0];
                    REG_PAUSE_TICKS:   regs.backoff_pause_ticks = cfg_data[7:0];
                    REG_UP_TICKS:      regs.backoff_up_ticks    = cfg_data[7:0];
                    default:           bad = bad;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                seen = {motor_enable, direction_up, height, arrived, limit_flags,
                        overcurrent_flags, homed};
                if (status_due.size() == 0)
                begin
                    $display("%0t lmpc: result with none expected, expected nothing got %h",
                             $time, seen);
                    bad++;
                end
                else
                begin
                    due = status_due.pop_front();
                    compare_field("motor_enable", due.motor_enable, seen.motor_enable);
                    compare_field("direction_up", due.direction_up, seen.direction_up);
                    compare_field("height", due.height, seen.height);
                    compare_field("arrived", due.arrived, seen.arrived);
                    compare_field("limit_flags", due.limit_flags, seen.limit_flags);
                    compare_field("overcurrent_flags", due.overcurrent_flags,
                                  seen.overcurrent_flags);
                    compare_field("homed", due.homed, seen.homed);
                end
            end
            if (in_valid && !in_stall)
            begin
                it = {func, target_height, upper_switch_n, lower_switch_n, motor_current};
                advance_lift(it, due);
                status_due.push_back(due);
            end
            waiting <= status_due.size();
            fails   <= bad;
        end
    end

endmodule

// File: dv/tb.sv
// testbench top: drives the lift controller, programs its registers and gives the verdict
`timescale 1ns / 100ps
module tb;
    import lmpc_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int PHASE_ITEMS = 220;
    localparam int HOLD_CYCLES = 60;
    localparam int WATCHDOG    = 1500;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           func;
    logic [7:0]           target_height;
    logic                 upper_switch_n;
    logic                 lower_switch_n;
    logic [11:0]          motor_current;
    logic                 out_valid;
    logic                 out_stall;
    logic                 motor_enable;
    logic                 direction_up;
    logic [7:0]           height;
    logic                 arrived;
    logic [1:0]           limit_flags;
    logic [1:0]           overcurrent_flags;
    logic                 homed;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int         waiting;
    int         fails;
    int         sent;
    int         rx_cycles;
    int         quiet_cycles = 0;
    bit         calm;
    bit         gaps_on;
    bit         stalls_on;
    int         hold_asks;
    int         holds_done;
    logic [11:0] cur_limit;
    cfg_t       plan [7];

    lift_motor_position_controller_core u_dut (.*);

    lmpc_motion_check u_check (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic item_t mk(input logic [1:0] f, input logic [7:0] tgt,
                                 input logic up_n, input logic low_n,
                                 input logic [11:0] amps);
        return {f, tgt, up_n, low_n, amps};
    endfunction

    function automatic cfg_t random_setup();
        cfg_t c;
        c.current_limit       = 12'($urandom_range(0, 4095));
        c.up_trip_count       = 8'($urandom_range(0, 40));
        c.down_trip_count     = 8'($urandom_range(0, 40));
        c.upper_limit_height  = 8'($urandom_range(0, 100));
        c.lower_limit_height  = 8'($urandom_range(0, 100));
        c.backoff_pause_ticks = 8'($urandom_range(0, 20));
        c.backoff_up_ticks    = 8'($urandom_range(0, 40));
        return c;
    endfunction

    task automatic offer(input item_t t);
        begin
            if (!calm && gaps_on && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid       <= 1'b1;
            func           <= t.func;
            target_height  <= t.target_height;
            upper_switch_n <= t.upper_switch_n;
            lower_switch_n <= t.lower_switch_n;
            motor_current  <= t.motor_current;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            sent++;
            if (sent % 50 == 0)
                gaps_on = $urandom_range(0, 1);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= d;
            @(posedge clk);
        end
    endtask

    task automatic settle();
        begin
            @(posedge clk);
            while (waiting != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        out_stall  = 1'b0;
        rx_cycles  = 0;
        stalls_on  = 1'b1;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles % 40 == 0)
                stalls_on = $urandom_range(0, 1);
            if (holds_done != hold_asks)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int         p;
        int         phase_end;
        int         ticks;
        int         burst;
        int         roll;
        logic [1:0] fn;
        logic [7:0] tgt;
        logic [11:0] amps;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = FUNC_TICK;
        target_height  = '0;
        upper_switch_n = 1'b1;
        lower_switch_n = 1'b1;
        motor_current  = '0;
        cfg_we         = 1'b0;
        cfg_index      = REG_CURRENT_LIMIT;
        cfg_data       = '0;
        calm           = 1'b0;
        gaps_on        = 1'b1;
        hold_asks      = 0;
        sent           = 0;
        burst          = 0;

        plan[0] = '{12'd1000, 8'd20, 8'd10, 8'd60, 8'd30, 8'd5, 8'd30};
        plan[1] = '{12'd0, 8'd1, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0};
        plan[2] = '{12'd4095, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255};
        plan[3] = '{12'd2000, 8'd0, 8'd0, 8'd50, 8'd50, 8'd1, 8'd3};
        plan[4] = '{12'd500, 8'd2, 8'd1, 8'd30, 8'd120, 8'd255, 8'd255};
        plan[5] = random_setup();
        plan[6] = random_setup();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < 7; p++)
        begin
            if (p != 0)
                settle();
            put_reg(REG_CURRENT_LIMIT, plan[p].current_limit);
            put_reg(REG_UP_TRIP, {4'($urandom), plan[p].up_trip_count});
            put_reg(REG_DOWN_TRIP, {4'($urandom), plan[p].down_trip_count});
            put_reg(REG_UPPER_HEIGHT, {4'($urandom), plan[p].upper_limit_height});
            put_reg(REG_LOWER_HEIGHT, {4'($urandom), plan[p].lower_limit_height});
            put_reg(REG_PAUSE_TICKS, {4'($urandom), plan[p].backoff_pause_ticks});
            put_reg(REG_UP_TICKS, {4'($urandom), plan[p].backoff_up_ticks});
            cfg_we <= 1'b0;
            cur_limit = plan[p].current_limit;

            if (p == 0)
            begin
                offer(mk(FUNC_TICK, 8'h00, 1'b1, 1'b1, 12'h000));
                offer(mk(FUNC_TICK, 8'hFF, 1'b0, 1'b0, 12'hFFF));
                offer(mk(FUNC_SPARE, 8'hFF, 1'b0, 1'b0, 12'hFFF));
                // target above full height keeps the lift climbing
                offer(mk(FUNC_SET, 8'hFF, 1'b1, 1'b1, 12'h000));
                repeat (3) offer(mk(FUNC_TICK, 8'h00, 1'b1, 1'b1, 12'hFFF));
                offer(mk(FUNC_SET, HEIGHT_FULL, 1'b1, 1'b1, 12'h000));
                repeat (2) offer(mk(FUNC_TICK, 8'h55, 1'b0, 1'b1, 12'd1000));
                offer(mk(FUNC_SET, 8'h00, 1'b1, 1'b1, 12'h000));
                repeat (3) offer(mk(FUNC_TICK, 8'hAA, 1'b1, 1'b0, 12'd1001));
                offer(mk(FUNC_STOP, 8'hAA, 1'b1, 1'b1, 12'h000));
                offer(mk(FUNC_TICK, 8'h00, 1'b1, 1'b1, 12'h000));
                offer(mk(FUNC_SET, HEIGHT_MID, 1'b1, 1'b1, 12'h000));
                repeat (2) offer(mk(FUNC_TICK, 8'h00, 1'b1, 1'b1, 12'h000));
                offer(mk(FUNC_STOP, 8'h00, 1'b0, 1'b0, 12'h000));
                offer(mk(FUNC_TICK, 8'h00, 1'b0, 1'b0, 12'h000));
            end

            calm = (p == 6);
            if (p == 1 || p == 4)
                hold_asks++;
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    offer(mk(2'($urandom_range(0, 3)), 8'($urandom),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             12'($urandom_range(0, 4095))));
                end
                else
                begin
                    // one trip: a target then a run of items, mostly ticks, with switch and current events
                    roll = $urandom_range(0, 9);
                    if (roll < 2)
                        tgt = 8'd0;
                    else if (roll < 4)
                        tgt = HEIGHT_FULL;
                    else if (roll == 4)
                        tgt = 8'($urandom_range(101, 255));
                    else
                        tgt = 8'($urandom_range(1, 99));
                    offer(mk(FUNC_SET, tgt, 1'b1, 1'b1, 12'($urandom_range(0, 4095))));
                    ticks = $urandom_range(10, 120);
                    while (ticks > 0 && sent < phase_end)
                    begin
                        ticks--;
                        roll = $urandom_range(0, 99);
                        if (roll < 3)
                            fn = FUNC_STOP;
                        else if (roll < 5)
                            fn = FUNC_SET;
                        else if (roll < 6)
                            fn = FUNC_SPARE;
                        else
                            fn = FUNC_TICK;
                        if (burst == 0 && $urandom_range(0, 11) == 0)
                            burst = $urandom_range(1, 30);
                        if (burst != 0)
                        begin
                            burst--;
                            if (cur_limit == 12'hFFF)
                                amps = 12'hFFF;
                            else
                                amps = 12'($urandom_range(int'(cur_limit) + 1, 4095));
                        end
                        else
                        begin
                            amps = 12'($urandom_range(0, int'(cur_limit)));
                        end
                        offer(mk(fn, 8'($urandom), $urandom_range(0, 9) != 0,
                                 $urandom_range(0, 9) != 0, amps));
                    end
                end
            end
            in_valid <= 1'b0;
        end

        settle();
        if (fails == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
